>>> rtl/drti_pkg.sv
// Package with the payload types, modes, classes and field constants of the rounding unit.
`timescale 1ns / 1ps
`default_nettype none
package drti_pkg;

  typedef enum logic [1:0] {
    MODE_TRUNC = 2'd0,
    MODE_FLOOR = 2'd1,
    MODE_CEIL  = 2'd2,
    MODE_ROUND = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CLASS_NAN       = 3'd0,
    CLASS_INF       = 3'd1,
    CLASS_ZERO      = 3'd2,
    CLASS_SUBNORMAL = 3'd3,
    CLASS_NORMAL    = 3'd4
  } class_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] value_bits;
  } in_item_t;

  typedef struct packed {
    logic [63:0] rounded_bits;
    logic [2:0]  operand_class;
  } out_item_t;

  localparam logic [10:0] EXP_OFFSET  = 11'd1023;
  localparam logic [10:0] EXP_ALL_ONE = 11'h7FF;
  localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
  localparam logic [51:0] FRAC_FIELD  = 52'hF_FFFF_FFFF_FFFF;
  localparam int unsigned QUIET_POS   = 51;

endpackage
`default_nettype wire

>>> rtl/drti_core.sv
// Combinational rounding and classification of one binary64 operand.
`timescale 1ns / 1ps
`default_nettype none
module drti_core (
  input  var drti_pkg::in_item_t  item,
  output var drti_pkg::out_item_t result
);

  logic        neg;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic [62:0] mag;
  logic [10:0] e;
  logic [51:0] mask;
  logic [51:0] low;
  logic [51:0] half;
  logic [63:0] kept;
  logic [63:0] step;
  logic        up;
  drti_pkg::mode_t  mode;
  drti_pkg::class_t cls;

  assign mode = drti_pkg::mode_t'(item.command);
  assign neg  = item.value_bits[63];
  assign bexp = item.value_bits[62:52];
  assign frac = item.value_bits[51:0];
  assign mag  = item.value_bits[62:0];
  assign e    = bexp - drti_pkg::EXP_OFFSET;
  assign mask = drti_pkg::FRAC_FIELD >> e[5:0];
  assign low  = frac & mask;
  assign half = (mask >> 1) ^ mask;
  assign kept = item.value_bits & ~{12'd0, mask};
  assign step = {12'd0, mask} + 64'd1;

  always_comb begin
    up = 1'b0;
    result.rounded_bits = item.value_bits;
    result.operand_class = cls;
    if (bexp == drti_pkg::EXP_ALL_ONE) begin
      if (frac != 52'd0 && mode != drti_pkg::MODE_TRUNC) begin
        result.rounded_bits[drti_pkg::QUIET_POS] = 1'b1;
      end
    end else if (bexp < drti_pkg::EXP_OFFSET) begin
      unique case (mode)
        drti_pkg::MODE_FLOOR: up = neg && mag != 63'd0;
        drti_pkg::MODE_CEIL:  up = !neg && mag != 63'd0;
        drti_pkg::MODE_ROUND: up = bexp == drti_pkg::EXP_OFFSET - 11'd1;
        default:              up = 1'b0;
      endcase
      result.rounded_bits = up ? ({neg, 63'd0} | drti_pkg::ONE_BITS) : {neg, 63'd0};
    end else if (e < 11'd52 && low != 52'd0) begin
      unique case (mode)
        drti_pkg::MODE_FLOOR: up = neg;
        drti_pkg::MODE_CEIL:  up = !neg;
        drti_pkg::MODE_ROUND: up = (low & half) != 52'd0;
        default:              up = 1'b0;
      endcase
      result.rounded_bits = up ? kept + step : kept;
    end
  end

  always_comb begin
    if (bexp == drti_pkg::EXP_ALL_ONE) begin
      cls = (frac != 52'd0) ? drti_pkg::CLASS_NAN : drti_pkg::CLASS_INF;
    end else if (bexp == 11'd0) begin
      cls = (frac != 52'd0) ? drti_pkg::CLASS_SUBNORMAL : drti_pkg::CLASS_ZERO;
    end else begin
      cls = drti_pkg::CLASS_NORMAL;
    end
  end

endmodule
`default_nettype wire

>>> rtl/double_round_to_integral.sv
// Top level of the binary64 round-to-integral unit with input and result registers.
//
// Usage: an input transaction carries a rounding mode (truncate, floor, ceiling,
// round half away from zero) and a binary64 operand as raw bits. Each input
// transaction produces exactly one output transaction with the integral result
// and the operand's class.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// The operand is first held in the input register; its result is then
// captured in the result register once that register can load. Throughput
// is one transaction per cycle while the receiver does not stall, set by the
// single combinational rounding stage.
// The two registers form a pipeline; in_stall is raised only when both hold
// data and the receiver stalls, so the block keeps accepting while a result
// waits as long as the input stage can move forward.
// Reset (synchronous, active high) clears both valid flags; payload
// registers are not reset. While the receiver stalls the result payload holds.
`timescale 1ns / 1ps
`default_nettype none
module double_round_to_integral (
  input  var logic                clk,
  input  var logic                rst,
  input  var logic                in_valid,
  output var logic                in_stall,
  input  var drti_pkg::in_item_t  in_data,
  output var logic                out_valid,
  input  var logic                out_stall,
  output var drti_pkg::out_item_t out_data
);

  logic                stage_valid;
  drti_pkg::in_item_t  stage_item;
  drti_pkg::out_item_t core_result;
  logic                out_move;
  logic                stage_move;

  // The result register can load when empty or being taken.
  assign out_move   = !out_valid || !out_stall;
  assign stage_move = !stage_valid || out_move;
  assign in_stall   = !stage_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_move) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move && in_valid) begin
      stage_item <= in_data;
    end
  end

  drti_core u_core (
    .item   (stage_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && stage_valid) begin
      out_data <= core_result;
    end
  end

endmodule
`default_nettype wire

>>> rtl/drti_checker.sv
// Port-level checker for the rounding unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module drti_port_checks (
  input var logic                clk,
  input var logic                rst,
  input var logic                in_valid,
  input var logic                in_stall,
  input var drti_pkg::out_item_t out_data,
  input var logic                out_valid,
  input var logic                out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without backpressure");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.operand_class <= drti_pkg::CLASS_NORMAL)
    else $error("class code out of range");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("result missing after two cycles");

endmodule

bind double_round_to_integral drti_port_checks u_drti_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
`default_nettype wire
